>>> rtl/lltp_pkg.sv
// Package for the thread placer: sizes, action and status codes, FSM states,
// and the thread record layout. Used by every module of the block.
package lltp_pkg;

   localparam int NUM_CPUS       = 8;
   localparam int NUM_PRIORITIES = 4;
   localparam int NUM_THREADS    = 64;
   localparam int CPU_W   = 3;
   localparam int PRIO_W  = 2;
   localparam int SLOT_W  = 6;
   localparam int CNT_W   = 7;
   localparam int CIDX_W  = CPU_W + PRIO_W;
   localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

   localparam logic [2:0] ACT_INIT  = 3'd0;
   localparam logic [2:0] ACT_READY = 3'd1;
   localparam logic [2:0] ACT_BLOCK = 3'd2;
   localparam logic [2:0] ACT_BOOST = 3'd3;
   localparam logic [2:0] ACT_EXIT  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_PHASE   = 2'd2;
   localparam logic [1:0] ST_NO_CPU  = 2'd3;

   localparam logic CSR_CPU_COUNT = 1'b0;
   localparam logic CSR_SCHED_RDY = 1'b1;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [7:0]        affinity;
      logic [CPU_W-1:0]  cpu;
      logic              assigned;
      logic              blocked;
      logic              raised;
      logic              died;
   } rec_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DECIDE, S_SCAN, S_CNT_READ, S_CNT_WRITE, S_RESP
   } state_type;

   // Count update request sent to the count store.
   typedef struct packed {
      logic              wr;
      logic [CIDX_W-1:0] idx;
      logic [CNT_W-1:0]  val;
   } cnt_wr_type;

endpackage

>>> rtl/lltp_count_store.sv
// Per-CPU, per-priority ready counts with registered read and one write port.
// Depends on lltp_pkg. Entries have valid bits, so invalid entries read as zero.
module lltp_count_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lltp_pkg::CIDX_W-1:0] rd_idx,
   output logic [lltp_pkg::CNT_W-1:0]  rd_data,
   input  lltp_pkg::cnt_wr_type        wr
);
   import lltp_pkg::*;

   localparam int DEPTH = NUM_CPUS * NUM_PRIORITIES;

   logic [CNT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0] data_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (wr.wr) begin
         mem[wr.idx] <= wr.val;
      end
      data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= valid_ff[rd_idx];
         if (wr.wr) begin
            valid_ff[wr.idx] <= 1'b1;
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;
endmodule

>>> rtl/least_loaded_cpu_thread_placer_core.sv
// Most actions go straight from the record read to the result strobe. A block or exit that
// unplaces a thread does one count read-modify-write, a boost of a placed thread does two, and a
// ready for an unplaced thread scans min(cpu_count,8) CPU counts, one CPU count a cycle, through
// the single comparator, then does one read-modify-write if a CPU was found. One word at a time;
// busy is high meanwhile. The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous reset clears all records and counts, sets the id counter to 1 and resets the registers.
module least_loaded_cpu_thread_placer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_thread_slot,
   input  logic [2:0]  req_priority_req,
   input  logic [7:0]  req_affinity_mask,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_thread_id,
   output logic        rsp_cpu_assigned,
   output logic [2:0]  rsp_assigned_cpu,
   output logic [1:0]  rsp_current_priority,
   output logic [6:0]  rsp_ready_total
);
   import lltp_pkg::*;

   state_type state_ff, state_in;

   logic [2:0]        act_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [2:0]        preq_ff;
   logic [7:0]        aff_ff;

   logic [3:0]  cpu_count_ff;
   logic        sched_ff;
   logic [31:0] next_id_ff;
   logic [CNT_W-1:0] total_ff;

   // Thread record memory with valid bits (invalid reads as all zero).
   rec_type            rec_mem [NUM_THREADS];
   logic [NUM_THREADS-1:0] rec_valid_ff;
   rec_type            rec_rd_ff;
   logic               rec_hit_ff;
   rec_type            rec_cur;
   rec_type            rec_ff;     // working copy
   logic               rec_we;

   logic [1:0]  status_ff;
   logic [31:0] tid_ff;

   // Decision on the record just read.
   rec_type     rec_dec;
   rec_type     rec_placed;
   logic [1:0]  status_dec;
   logic        init_ok;
   logic        scan_go;
   logic        unplace;
   logic        boost_move;

   // Scan state.
   logic [CPU_W:0]   scan_ff;
   logic             found_ff;
   logic [CPU_W-1:0] best_ff;
   logic [CNT_W-1:0] best_cnt_ff;
   logic             scan_pend_ff;  // the count read in flight is for an allowed CPU
   logic             scan_done;

   // Count update sequence: up to two read-modify-writes.
   logic             step2_ff;
   logic [CIDX_W-1:0] c_idx_ff;
   logic             c_inc_ff;
   logic             has2_ff;
   logic [CIDX_W-1:0] c_idx2_ff;

   logic [CIDX_W-1:0] cnt_rd_idx;
   logic [CNT_W-1:0]  cnt_rd;
   cnt_wr_type        cnt_wr;

   logic [CPU_W:0] n_cpus;

   assign n_cpus = (cpu_count_ff > 4'(NUM_CPUS)) ? (CPU_W+1)'(NUM_CPUS)
                                                 : cpu_count_ff[CPU_W:0];
   assign rec_cur = rec_hit_ff ? rec_rd_ff : '0;
   assign csr_ready = (state_ff == S_IDLE);
   assign scan_done = (scan_ff == n_cpus) && !scan_pend_ff;

   lltp_count_store u_cnt (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (cnt_rd_idx),
      .rd_data (cnt_rd),
      .wr      (cnt_wr)
   );

   always_comb begin
      if (state_ff == S_SCAN) begin
         cnt_rd_idx = {scan_ff[CPU_W-1:0], rec_ff.prio};
      end else begin
         cnt_rd_idx = step2_ff ? c_idx2_ff : c_idx_ff;
      end
   end

   always_comb begin
      cnt_wr.wr  = (state_ff == S_CNT_WRITE);
      cnt_wr.idx = step2_ff ? c_idx2_ff : c_idx_ff;
      if (c_inc_ff && !step2_ff || step2_ff) begin
         cnt_wr.val = (cnt_rd < COUNT_MAX) ? cnt_rd + 1'b1 : cnt_rd;
      end else begin
         cnt_wr.val = (cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;
      end
   end

   // Action decode on the record read for this word.
   always_comb begin
      rec_dec    = rec_cur;
      status_dec = ST_OK;
      init_ok    = 1'b0;
      scan_go    = 1'b0;
      unplace    = 1'b0;
      boost_move = 1'b0;
      case (act_ff)
         ACT_INIT: begin
            if (preq_ff > 3'(NUM_PRIORITIES-1) || aff_ff == '0 || rec_cur.assigned) begin
               status_dec = ST_INVALID;
            end else begin
               init_ok = 1'b1;
               rec_dec = '{prio: preq_ff[PRIO_W-1:0], affinity: aff_ff,
                           cpu: '0, assigned: 1'b0, blocked: 1'b0,
                           raised: 1'b0, died: 1'b0};
            end
         end
         ACT_READY: begin
            if (!sched_ff) begin
               status_dec = ST_PHASE;
            end else if (!rec_cur.assigned) begin
               scan_go = 1'b1;
            end
         end
         ACT_BLOCK, ACT_EXIT: begin
            if (act_ff == ACT_BLOCK && !rec_cur.assigned) begin
               status_dec = ST_INVALID;
            end else begin
               if (rec_cur.assigned && !rec_cur.blocked) begin
                  unplace          = 1'b1;
                  rec_dec.raised   = 1'b0;
                  rec_dec.blocked  = 1'b1;
                  rec_dec.assigned = 1'b0;
                  rec_dec.cpu      = '0;
               end
               if (act_ff == ACT_EXIT) begin
                  rec_dec.died = 1'b1;
               end
            end
         end
         ACT_BOOST: begin
            if (rec_cur.died || (!rec_cur.assigned && !rec_cur.blocked)) begin
               status_dec = ST_INVALID;
            end else if (!rec_cur.raised &&
                         rec_cur.prio < PRIO_W'(NUM_PRIORITIES-1)) begin
               rec_dec.raised = 1'b1;
               rec_dec.prio   = rec_cur.prio + 1'b1;
               boost_move     = rec_cur.assigned;
            end
         end
         default: status_dec = ST_INVALID;
      endcase
   end

   always_comb begin
      rec_placed          = rec_ff;
      rec_placed.assigned = 1'b1;
      rec_placed.cpu      = best_ff;
      rec_placed.blocked  = 1'b0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (start) state_in = S_READ;
         S_READ:      state_in = S_DECIDE;
         S_DECIDE: begin
            if (scan_go) begin
               state_in = S_SCAN;
            end else if (unplace || boost_move) begin
               state_in = S_CNT_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN:      if (scan_done) state_in = found_ff ? S_CNT_READ : S_RESP;
         S_CNT_READ:  state_in = S_CNT_WRITE;
         S_CNT_WRITE: state_in = (has2_ff && !step2_ff) ? S_CNT_READ : S_RESP;
         S_RESP:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      rec_we    = (state_ff == S_RESP);
      rsp_status           = status_ff;
      rsp_thread_id        = tid_ff;
      rsp_cpu_assigned     = rec_ff.assigned;
      rsp_assigned_cpu     = rec_ff.assigned ? rec_ff.cpu : '0;
      rsp_current_priority = rec_ff.prio;
      rsp_ready_total      = total_ff;
   end

   always_ff @(posedge clock) begin
      rec_rd_ff <= rec_mem[slot_ff];
      if (rec_we) begin
         rec_mem[slot_ff] <= rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cpu_count_ff <= 4'd8;
         sched_ff     <= 1'b0;
         next_id_ff   <= 32'd1;
         total_ff     <= '0;
         rec_valid_ff <= '0;
         rec_hit_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rec_hit_ff <= rec_valid_ff[slot_ff];
         if (rec_we) begin
            rec_valid_ff[slot_ff] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CPU_COUNT: cpu_count_ff <= csr_data;
               CSR_SCHED_RDY: sched_ff     <= csr_data[0];
               default:       ;
            endcase
         end
         if (state_ff == S_DECIDE && init_ok) begin
            next_id_ff <= next_id_ff + 32'd1;
         end
         if (state_ff == S_DECIDE && unplace) begin
            total_ff <= (total_ff != '0) ? total_ff - 1'b1 : total_ff;
         end
         if (state_ff == S_SCAN && scan_done && found_ff) begin
            total_ff <= (total_ff < COUNT_MAX) ? total_ff + 1'b1 : total_ff;
         end
      end
   end

   // Datapath sequencing.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            act_ff   <= req_action;
            slot_ff  <= req_thread_slot;
            preq_ff  <= req_priority_req;
            aff_ff   <= req_affinity_mask;
            step2_ff <= 1'b0;
            has2_ff  <= 1'b0;
         end
         S_DECIDE: begin
            rec_ff    <= rec_dec;
            status_ff <= status_dec;
            tid_ff    <= init_ok ? next_id_ff : '0;
            scan_ff   <= '0;
            found_ff  <= 1'b0;
            best_ff   <= '0;
            best_cnt_ff <= '0;
            scan_pend_ff <= 1'b0;
            c_idx_ff  <= {rec_cur.cpu, rec_cur.prio};
            c_idx2_ff <= {rec_cur.cpu, rec_cur.prio + 1'b1};
            c_inc_ff  <= 1'b0;
            has2_ff   <= boost_move;
         end
         S_SCAN: begin
            // One count read per cycle; compare the previous read's data.
            if (scan_pend_ff) begin
               if (!found_ff || cnt_rd < best_cnt_ff) begin
                  found_ff    <= 1'b1;
                  best_ff     <= scan_ff[CPU_W-1:0] - 1'b1;
                  best_cnt_ff <= cnt_rd;
               end
            end
            if (scan_ff != n_cpus) begin
               scan_pend_ff <= rec_ff.affinity[scan_ff[CPU_W-1:0]];
               scan_ff      <= scan_ff + 1'b1;
            end else begin
               scan_pend_ff <= 1'b0;
               if (!scan_pend_ff) begin
                  if (found_ff) begin
                     rec_ff   <= rec_placed;
                     c_idx_ff <= {best_ff, rec_ff.prio};
                     c_inc_ff <= 1'b1;
                  end else begin
                     status_ff <= ST_NO_CPU;
                  end
               end
            end
         end
         S_CNT_WRITE: begin
            if (has2_ff && !step2_ff) begin
               step2_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule

>>> dv/tb_top.sv
// Self-checking testbench for least_loaded_cpu_thread_placer_core.
// It runs a directed table and then random phases against an in-bench placement predictor.
// It depends on lltp_pkg for its types and codes.
module tb_top;
   import lltp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ACT_BAD_LO = 3'd5;
   localparam logic [2:0] ACT_BAD_HI = 3'd7;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] tid;
      logic        assigned;
      logic [2:0]  cpu;
      logic [1:0]  prio;
      logic [6:0]  total;
   } placement_type;

   typedef struct {
      bit            is_cfg;
      logic          csr_idx;
      logic [3:0]    csr_val;
      logic [2:0]    act;
      logic [5:0]    slot;
      logic [2:0]    prq;
      logic [7:0]    aff;
      bit            typed;
      placement_type res;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [5:0]  req_thread_slot = '0;
   logic [2:0]  req_priority_req = '0;
   logic [7:0]  req_affinity_mask = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_data = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_thread_id;
   logic        rsp_cpu_assigned;
   logic [2:0]  rsp_assigned_cpu;
   logic [1:0]  rsp_current_priority;
   logic [6:0]  rsp_ready_total;

   least_loaded_cpu_thread_placer_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: thread table, per-CPU/priority counts, id counter, registers.
   rec_type          threads [NUM_THREADS];
   logic [CNT_W-1:0] load [NUM_CPUS*NUM_PRIORITIES];
   logic [31:0]      id_next;
   logic [CNT_W-1:0] load_total;
   logic [3:0]       cfg_cpus;
   logic             cfg_sched;

   placement_type pending[$];
   int            errors = 0;
   row_type       table_rows[$];

   function automatic int load_idx(logic [2:0] c, logic [1:0] p);
      return int'({c, p});
   endfunction

   function automatic void unplace(int s);
      if (!threads[s].blocked) begin
         if (load[load_idx(threads[s].cpu, threads[s].prio)] != 0)
            load[load_idx(threads[s].cpu, threads[s].prio)]--;
         if (load_total != 0) load_total--;
         threads[s].raised = 1'b0;
         threads[s].blocked = 1'b1;
         threads[s].assigned = 1'b0;
         threads[s].cpu = '0;
      end
   endfunction

   function automatic placement_type place_thread(logic [2:0] act, logic [5:0] slot,
                                                  logic [2:0] prq, logic [7:0] aff);
      placement_type r;
      int n, best, s;
      bit found;
      logic [1:0] up;
      r = '0;
      s = slot;
      case (act)
         ACT_INIT: begin
            if (prq > NUM_PRIORITIES - 1 || aff == 0 || threads[s].assigned) begin
               r.status = ST_INVALID;
            end else begin
               threads[s] = '0;
               threads[s].prio = prq[1:0];
               threads[s].affinity = aff;
               r.tid = id_next;
               id_next++;
            end
         end
         ACT_READY: begin
            if (!cfg_sched) begin
               r.status = ST_PHASE;
            end else if (!threads[s].assigned) begin
               n = (cfg_cpus > NUM_CPUS) ? NUM_CPUS : cfg_cpus;
               found = 0;
               best = 0;
               for (int i = 0; i < n; i++) begin
                  if (threads[s].affinity[i] && (!found ||
                      load[load_idx(3'(i), threads[s].prio)] <
                      load[load_idx(3'(best), threads[s].prio)])) begin
                     best = i;
                     found = 1;
                  end
               end
               if (!found) begin
                  r.status = ST_NO_CPU;
               end else begin
                  threads[s].assigned = 1'b1;
                  threads[s].cpu = 3'(best);
                  threads[s].blocked = 1'b0;
                  if (load_total != COUNT_MAX) load_total++;
                  if (load[load_idx(3'(best), threads[s].prio)] != COUNT_MAX)
                     load[load_idx(3'(best), threads[s].prio)]++;
               end
            end
         end
         ACT_BLOCK: begin
            if (!threads[s].assigned) r.status = ST_INVALID;
            else unplace(s);
         end
         ACT_BOOST: begin
            if (threads[s].died || (!threads[s].assigned && !threads[s].blocked)) begin
               r.status = ST_INVALID;
            end else if (!threads[s].raised && threads[s].prio < NUM_PRIORITIES - 1) begin
               if (threads[s].assigned) begin
                  up = threads[s].prio + 2'd1;
                  if (load[load_idx(threads[s].cpu, threads[s].prio)] != 0)
                     load[load_idx(threads[s].cpu, threads[s].prio)]--;
                  if (load[load_idx(threads[s].cpu, up)] != COUNT_MAX)
                     load[load_idx(threads[s].cpu, up)]++;
               end
               threads[s].raised = 1'b1;
               threads[s].prio++;
            end
         end
         ACT_EXIT: begin
            if (threads[s].assigned) unplace(s);
            threads[s].died = 1'b1;
         end
         default: r.status = ST_INVALID;
      endcase
      r.assigned = threads[s].assigned;
      r.cpu = threads[s].assigned ? threads[s].cpu : 3'd0;
      r.prio = threads[s].prio;
      r.total = load_total;
      return r;
   endfunction

   // Drive one word; returns at the falling edge after it was accepted.
   task automatic send_word(logic [2:0] act, logic [5:0] slot, logic [2:0] prq,
                            logic [7:0] aff, bit typed, placement_type typed_res);
      placement_type p;
      start <= 1'b1;
      req_action <= act;
      req_thread_slot <= slot;
      req_priority_req <= prq;
      req_affinity_mask <= aff;
      do @(posedge clock); while (busy);
      p = place_thread(act, slot, prq, aff);
      pending.push_back(typed ? typed_res : p);
      @(negedge clock);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return;
      if (r < 95) pause($urandom_range(1, 3));
      else pause($urandom_range(10, 40));
   endtask

   // Wait until every expected word has come and the block has settled.
   task automatic drain();
      start <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [3:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CPU_COUNT) cfg_cpus = val;
      else cfg_sched = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_item(logic [2:0] act, logic [5:0] slot, logic [2:0] prq,
                           logic [7:0] aff);
      row_type r;
      r = '{default: '0};
      r.act = act; r.slot = slot; r.prq = prq; r.aff = aff;
      table_rows.push_back(r);
   endtask

   task automatic add_typed(logic [2:0] act, logic [5:0] slot, logic [2:0] prq,
                            logic [7:0] aff, placement_type res);
      add_item(act, slot, prq, aff);
      table_rows[$].typed = 1;
      table_rows[$].res = res;
   endtask

   task automatic add_cfg(logic idx, logic [3:0] val);
      row_type r;
      r = '{default: '0};
      r.is_cfg = 1; r.csr_idx = idx; r.csr_val = val;
      table_rows.push_back(r);
   endtask

   always @(posedge clock) begin
      placement_type e;
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            $error("unexpected result word, status %0d", rsp_status);
            errors++;
         end else begin
            e = pending.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d act %0d", e.status, rsp_status); errors++;
            end
            if (rsp_thread_id !== e.tid) begin
               $error("thread_id exp %0d act %0d", e.tid, rsp_thread_id); errors++;
            end
            if (rsp_cpu_assigned !== e.assigned) begin
               $error("cpu_assigned exp %0d act %0d", e.assigned, rsp_cpu_assigned);
               errors++;
            end
            if (rsp_assigned_cpu !== e.cpu) begin
               $error("assigned_cpu exp %0d act %0d", e.cpu, rsp_assigned_cpu); errors++;
            end
            if (rsp_current_priority !== e.prio) begin
               $error("current_priority exp %0d act %0d", e.prio, rsp_current_priority);
               errors++;
            end
            if (rsp_ready_total !== e.total) begin
               $error("ready_total exp %0d act %0d", e.total, rsp_ready_total); errors++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      logic [2:0] act;
      logic [2:0] prq;
      logic [7:0] aff;
      logic [5:0] slot;
      int pick;
      for (int i = 0; i < NUM_THREADS; i++) threads[i] = '0;
      for (int i = 0; i < NUM_CPUS*NUM_PRIORITIES; i++) load[i] = '0;
      id_next = 32'd1;
      load_total = '0;
      cfg_cpus = 4'd8;
      cfg_sched = 1'b0;

      // Straight after reset: results read directly off the empty table.
      add_typed(ACT_READY, 6'd0, 3'd0, 8'h00, '{ST_PHASE, 0, 0, 0, 0, 0});
      add_typed(ACT_INIT, 6'd0, 3'd7, 8'hff, '{ST_INVALID, 0, 0, 0, 0, 0});
      add_typed(ACT_INIT, 6'd0, 3'd0, 8'h00, '{ST_INVALID, 0, 0, 0, 0, 0});
      add_typed(ACT_INIT, 6'd0, 3'd3, 8'hff, '{ST_OK, 1, 0, 0, 3, 0});
      add_typed(ACT_BAD_HI, 6'd63, 3'd7, 8'hff, '{ST_INVALID, 0, 0, 0, 0, 0});
      add_typed(ACT_BLOCK, 6'd0, 3'd0, 8'h00, '{ST_INVALID, 0, 0, 0, 3, 0});
      add_typed(ACT_BOOST, 6'd0, 3'd0, 8'h00, '{ST_INVALID, 0, 0, 0, 3, 0});
      add_cfg(CSR_SCHED_RDY, 4'd1);
      add_item(ACT_READY, 6'd0, 3'd0, 8'h00);
      add_item(ACT_INIT, 6'd63, 3'd0, 8'h80);
      add_item(ACT_READY, 6'd63, 3'd0, 8'h00);
      add_item(ACT_READY, 6'd63, 3'd0, 8'h00);
      add_item(ACT_INIT, 6'd63, 3'd1, 8'h01);
      add_item(ACT_BOOST, 6'd63, 3'd0, 8'h00);
      add_item(ACT_BOOST, 6'd63, 3'd0, 8'h00);
      add_item(ACT_BLOCK, 6'd63, 3'd0, 8'h00);
      add_item(ACT_BOOST, 6'd63, 3'd0, 8'h00);
      add_item(ACT_EXIT, 6'd63, 3'd0, 8'h00);
      add_item(ACT_EXIT, 6'd0, 3'd0, 8'h00);
      add_item(ACT_READY, 6'd63, 3'd0, 8'h00);
      add_item(ACT_BOOST, 6'd63, 3'd0, 8'h00);
      add_cfg(CSR_CPU_COUNT, 4'd1);
      add_item(ACT_INIT, 6'd2, 3'd0, 8'h80);
      add_item(ACT_READY, 6'd2, 3'd0, 8'h00);
      add_item(ACT_INIT, 6'd1, 3'd2, 8'h01);
      add_item(ACT_READY, 6'd1, 3'd0, 8'h00);
      add_item(ACT_BAD_LO, 6'd1, 3'd0, 8'h00);

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (table_rows[i]) begin
         if (table_rows[i].is_cfg) begin
            write_reg(table_rows[i].csr_idx, table_rows[i].csr_val);
         end else begin
            send_word(table_rows[i].act, table_rows[i].slot, table_rows[i].prq,
                      table_rows[i].aff, table_rows[i].typed, table_rows[i].res);
            random_gap();
         end
      end

      // Random phases; each register change waits for the block to go quiet.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_CPU_COUNT, 4'd8); write_reg(CSR_SCHED_RDY, 4'd1); end
            1: write_reg(CSR_CPU_COUNT, 4'd3);
            2: write_reg(CSR_CPU_COUNT, 4'd15);
            3: write_reg(CSR_CPU_COUNT, 4'd0);
            4: begin write_reg(CSR_CPU_COUNT, 4'd5); write_reg(CSR_SCHED_RDY, 4'd0); end
            default: begin
               write_reg(CSR_CPU_COUNT, 4'd8); write_reg(CSR_SCHED_RDY, 4'd1);
            end
         endcase
         for (int k = 0; k < 65; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) act = ACT_INIT;
            else if (pick < 55) act = ACT_READY;
            else if (pick < 70) act = ACT_BLOCK;
            else if (pick < 85) act = ACT_BOOST;
            else if (pick < 95) act = ACT_EXIT;
            else act = 3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
            slot = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 11));
            prq = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
            aff = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            send_word(act, slot, prq, aff, 0, '0);
            random_gap();
         end
      end

      drain();
      if (errors == 0 && pending.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/lltp_pkg.sv
rtl/lltp_count_store.sv
rtl/least_loaded_cpu_thread_placer_core.sv
dv/tb_top.sv
